>>> sv/nnsg_pkg.sv
// Shared types and constants of the nearest-neighbor scaler with gray output.
// Used by nearest_neighbor_scale_to_gray_unit and the testbench; depends on nothing.
`default_nettype none

package nnsg_pkg;

    // Field and counter widths
    localparam int SRC_DIM_W   = 9;      // source sizes 1..256
    localparam int TGT_DIM_W   = 13;     // target sizes 1..4096
    localparam int POS_W       = 12;     // output column and row position
    localparam int QUO_W       = 8;      // scaled source coordinate, always below 256
    localparam int STORE_DEPTH = 65536;  // source pixel store entries
    localparam int STORE_AW    = 16;
    localparam int STORE_DW    = 32;
    localparam int CFG_ADDR_W  = 5;
    localparam int CFG_DATA_W  = 32;

    // Size limits used when a configuration write is clamped
    localparam logic [SRC_DIM_W-1:0] SRC_DIM_MAX = 9'd256;
    localparam logic [TGT_DIM_W-1:0] TGT_DIM_MAX = 13'd4096;

    // Luminance weights, 16-bit fractions that sum to 65536
    localparam logic [23:0] GRAY_W_R = 24'd19595;
    localparam logic [23:0] GRAY_W_G = 24'd38470;
    localparam logic [23:0] GRAY_W_B = 24'd7471;

    // Register index codes (byte address is 4 * index)
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_TGT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_TGT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_CHANNELS   = 3'd4;

    // Channel count codes
    localparam logic [2:0] CH_RGB  = 3'd3;
    localparam logic [2:0] CH_RGBA = 3'd4;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic [7:0] gray_level;
        logic       frame_end;
    } out_item_t;

endpackage

`default_nettype wire

>>> sv/nnsg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; holds the source pixel store of the scaler.
`default_nettype none

module nnsg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/nearest_neighbor_scale_to_gray_unit.sv
// Nearest-neighbor image scaler with gray output: top level.
// Depends on nnsg_pkg and nnsg_ram (source pixel store).
//
// Usage: the s_ channel carries one item per transfer. A load item (op = 0)
// writes one source pixel in raster order and gives no result; the unit
// stays ready for the next item. An emit item (op = 1) gives the next output
// pixel of the resized image, in raster order, on the m_ channel, with a
// gray level and frame_end on the last pixel; the position wraps to the
// top left after it. One shared restoring divider resolves one quotient bit
// per cycle, first for the column and then for the row, with a multiply
// step before each division; then a step forms the store address and starts
// the read, and a last step weights the read pixel into the output register.
// s_ready is high only between items, so no new item is taken while an emit
// is being worked on.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver stalls, a following emit holds in its last step, with
// s_ready low, until the register frees up.
// Reset (aresetn low, synchronous) clears the load pointer, the output
// position and the sequencer, and sets the sizes to 256x256 to 256x256 RGB.
// The store content is undefined until loaded; there is no clearing pass.
// The user must configure through the APB port only while no emit is in flight; the block does not enforce this.
`default_nettype none

module nearest_neighbor_scale_to_gray_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Item input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire nnsg_pkg::in_item_t                  s_data,
    // Result output channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output nnsg_pkg::out_item_t                      m_data,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [nnsg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [nnsg_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [nnsg_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    // Sequencer state codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ADDR = 3'd3;
    localparam logic [2:0] ST_GRAY = 3'd4;

    // Zero maps to 1, above 256 saturates
    function automatic logic [nnsg_pkg::SRC_DIM_W-1:0] clamp_src(
        input logic [nnsg_pkg::SRC_DIM_W-1:0] v);
        logic [nnsg_pkg::SRC_DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = nnsg_pkg::SRC_DIM_W'(1);
        end else if (v > nnsg_pkg::SRC_DIM_MAX) begin
            r = nnsg_pkg::SRC_DIM_MAX;
        end
        return r;
    endfunction

    // Zero maps to 1, above 4096 saturates
    function automatic logic [nnsg_pkg::TGT_DIM_W-1:0] clamp_tgt(
        input logic [nnsg_pkg::TGT_DIM_W-1:0] v);
        logic [nnsg_pkg::TGT_DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = nnsg_pkg::TGT_DIM_W'(1);
        end else if (v > nnsg_pkg::TGT_DIM_MAX) begin
            r = nnsg_pkg::TGT_DIM_MAX;
        end
        return r;
    endfunction

    // Configuration registers
    logic [nnsg_pkg::SRC_DIM_W-1:0] src_w_reg, src_w_next;
    logic [nnsg_pkg::SRC_DIM_W-1:0] src_h_reg, src_h_next;
    logic [nnsg_pkg::TGT_DIM_W-1:0] tgt_w_reg, tgt_w_next;
    logic [nnsg_pkg::TGT_DIM_W-1:0] tgt_h_reg, tgt_h_next;
    logic                           rgba_reg,  rgba_next;

    // Control state
    logic [2:0]                     state_reg, state_next;
    logic [nnsg_pkg::STORE_AW-1:0]  ptr_reg,   ptr_next;
    logic [nnsg_pkg::POS_W-1:0]     col_reg,   col_next;
    logic [nnsg_pkg::POS_W-1:0]     row_reg,   row_next;
    logic                           phase_reg, phase_next;
    logic [2:0]                     cnt_reg,   cnt_next;
    logic                           m_valid_reg, m_valid_next;

    // Working payload
    logic [nnsg_pkg::POS_W-1:0]     x_reg,     x_next;
    logic [nnsg_pkg::POS_W-1:0]     y_reg,     y_next;
    logic                           last_reg,  last_next;
    logic [nnsg_pkg::TGT_DIM_W-1:0] rem_reg,   rem_next;
    logic [nnsg_pkg::QUO_W-1:0]     shift_reg, shift_next;
    logic [nnsg_pkg::QUO_W-1:0]     sx_reg,    sx_next;
    nnsg_pkg::out_item_t            out_reg,   out_next;

    // Combinational helpers
    logic                           cfg_wr;
    logic [2:0]                     cfg_idx;
    logic [nnsg_pkg::POS_W-1:0]     x_norm, y_norm;
    logic [nnsg_pkg::POS_W+nnsg_pkg::SRC_DIM_W-1:0] prod;
    logic [nnsg_pkg::TGT_DIM_W-1:0] divisor;
    logic [nnsg_pkg::TGT_DIM_W:0]   trial;
    logic                           ge;
    logic [nnsg_pkg::TGT_DIM_W:0]   diff;
    logic [2*nnsg_pkg::SRC_DIM_W-1:0] total;
    logic [nnsg_pkg::STORE_AW:0]    ptr_inc;
    logic [nnsg_pkg::STORE_AW:0]    addr_sum;
    logic [nnsg_pkg::STORE_DW-1:0]  pix;
    logic [23:0]                    gray_sum;
    logic                           ram_wr_en;
    logic                           ram_rd_en;

    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // Register readback
    always_comb begin
        case (cfg_idx)
            nnsg_pkg::REG_SRC_WIDTH:  prdata = {23'd0, src_w_reg};
            nnsg_pkg::REG_SRC_HEIGHT: prdata = {23'd0, src_h_reg};
            nnsg_pkg::REG_TGT_WIDTH:  prdata = {19'd0, tgt_w_reg};
            nnsg_pkg::REG_TGT_HEIGHT: prdata = {19'd0, tgt_h_reg};
            nnsg_pkg::REG_CHANNELS:
                prdata = {29'd0, (rgba_reg ? nnsg_pkg::CH_RGBA : nnsg_pkg::CH_RGB)};
            default:                  prdata = '0;
        endcase
    end

    // Configuration writes
    always_comb begin
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        tgt_w_next = tgt_w_reg;
        tgt_h_next = tgt_h_reg;
        rgba_next  = rgba_reg;
        if (cfg_wr) begin
            case (cfg_idx)
                nnsg_pkg::REG_SRC_WIDTH:  src_w_next = clamp_src(pwdata[8:0]);
                nnsg_pkg::REG_SRC_HEIGHT: src_h_next = clamp_src(pwdata[8:0]);
                nnsg_pkg::REG_TGT_WIDTH:  tgt_w_next = clamp_tgt(pwdata[12:0]);
                nnsg_pkg::REG_TGT_HEIGHT: tgt_h_next = clamp_tgt(pwdata[12:0]);
                nnsg_pkg::REG_CHANNELS:   rgba_next  = (pwdata[2:0] == nnsg_pkg::CH_RGBA);
                default: ;
            endcase
        end
    end

    // Drop a stale position after a target size was lowered
    assign x_norm = ({1'b0, col_reg} >= tgt_w_reg) ? '0 : col_reg;
    assign y_norm = ({1'b0, row_reg} >= tgt_h_reg) ? '0 : row_reg;

    // Shared multiplier and restoring divider step
    assign prod    = {9'd0, (phase_reg ? y_reg : x_reg)} *
                     {12'd0, (phase_reg ? src_h_reg : src_w_reg)};
    assign divisor = phase_reg ? tgt_h_reg : tgt_w_reg;
    assign trial   = {rem_reg, shift_reg[nnsg_pkg::QUO_W-1]};
    assign ge      = (trial >= {1'b0, divisor});
    assign diff    = trial - {1'b0, divisor};

    // Load pointer wrap
    assign total   = {9'd0, src_w_reg} * {9'd0, src_h_reg};
    assign ptr_inc = {1'b0, ptr_reg} + 17'd1;

    // Store address: row times width plus column, modulo the store size
    assign addr_sum = {9'd0, shift_reg} * {8'd0, src_w_reg} + {9'd0, sx_reg};

    // Gray weighting of the read pixel
    assign gray_sum = nnsg_pkg::GRAY_W_R * {16'd0, pix[7:0]}
                    + nnsg_pkg::GRAY_W_G * {16'd0, pix[15:8]}
                    + nnsg_pkg::GRAY_W_B * {16'd0, pix[23:16]};

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        last_next    = last_reg;
        rem_next     = rem_reg;
        shift_next   = shift_reg;
        sx_next      = sx_reg;
        out_next     = out_reg;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;

        // Retire the held result on its transfer
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.op == nnsg_pkg::OP_LOAD) begin
                        ram_wr_en = 1'b1;
                        if (ptr_inc[nnsg_pkg::STORE_AW] || ({1'b0, ptr_inc} >= total)) begin
                            ptr_next = '0;
                        end else begin
                            ptr_next = ptr_inc[nnsg_pkg::STORE_AW-1:0];
                        end
                    end else begin
                        x_next     = x_norm;
                        y_next     = y_norm;
                        last_next  = ({1'b0, x_norm} + 13'd1 == tgt_w_reg) &&
                                     ({1'b0, y_norm} + 13'd1 == tgt_h_reg);
                        phase_next = 1'b0;
                        state_next = ST_MUL;
                        // Advance the output position, wrap at the frame end
                        if ({1'b0, x_norm} + 13'd1 >= tgt_w_reg) begin
                            col_next = '0;
                            if ({1'b0, y_norm} + 13'd1 >= tgt_h_reg) begin
                                row_next = '0;
                            end else begin
                                row_next = y_norm + 12'd1;
                            end
                        end else begin
                            col_next = x_norm + 12'd1;
                        end
                    end
                end
            end
            ST_MUL: begin
                // Product is below 256 times the divisor: 8 quotient bits
                rem_next   = prod[20:8];
                shift_next = prod[7:0];
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next   = ge ? diff[nnsg_pkg::TGT_DIM_W-1:0]
                                : trial[nnsg_pkg::TGT_DIM_W-1:0];
                shift_next = {shift_reg[nnsg_pkg::QUO_W-2:0], ge};
                cnt_next   = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    if (!phase_reg) begin
                        sx_next    = {shift_reg[nnsg_pkg::QUO_W-2:0], ge};
                        phase_next = 1'b1;
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_ADDR;
                    end
                end
            end
            ST_ADDR: begin
                ram_rd_en  = 1'b1;
                state_next = ST_GRAY;
            end
            ST_GRAY: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_next.out_red    = pix[7:0];
                    out_next.out_green  = pix[15:8];
                    out_next.out_blue   = pix[23:16];
                    out_next.out_alpha  = rgba_reg ? pix[31:24] : 8'd0;
                    out_next.gray_level = gray_sum[23:16];
                    out_next.frame_end  = last_reg;
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg   <= nnsg_pkg::SRC_DIM_MAX;
            src_h_reg   <= nnsg_pkg::SRC_DIM_MAX;
            tgt_w_reg   <= 13'd256;
            tgt_h_reg   <= 13'd256;
            rgba_reg    <= 1'b0;
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            phase_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            src_w_reg   <= src_w_next;
            src_h_reg   <= src_h_next;
            tgt_w_reg   <= tgt_w_next;
            tgt_h_reg   <= tgt_h_next;
            rgba_reg    <= rgba_next;
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        last_reg  <= last_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        sx_reg    <= sx_next;
        out_reg   <= out_next;
    end

    // Source pixel store
    nnsg_ram #(
        .WIDTH (nnsg_pkg::STORE_DW),
        .DEPTH (nnsg_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ptr_reg),
        .wr_data ({s_data.in_alpha, s_data.in_blue, s_data.in_green, s_data.in_red}),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_sum[nnsg_pkg::STORE_AW-1:0]),
        .rd_data (pix)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for nearest_neighbor_scale_to_gray_unit.
// Depends on nnsg_pkg and the scaler RTL. A scaler model inside the bench predicts each
// output pixel from the accepted input transfers and the register writes.
`timescale 1ns / 100ps

module tb;
    import nnsg_pkg::*;

    localparam int MIRROR_DEPTH = STORE_DEPTH;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 1600;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Scaler model state: pixel store copy, load pointer, output position, sizes
    logic [31:0] pixel_mirror [MIRROR_DEPTH];
    bit          pixel_loaded [MIRROR_DEPTH];
    int unsigned load_addr;
    int unsigned out_col;
    int unsigned out_row;
    int unsigned src_w;
    int unsigned src_h;
    int unsigned tgt_w;
    int unsigned tgt_h;
    logic [2:0]  chan_code;
    out_item_t   pending_pixels [$];

    // Run bookkeeping
    int          mismatches = 0;
    int unsigned n_loads    = 0;
    int unsigned n_emits    = 0;
    int unsigned n_frames   = 0;
    int unsigned n_phases   = 0;
    bit          steady_mode = 1'b0;
    int unsigned hold_request = 0;
    int unsigned stall_left   = 0;
    out_item_t   expected_px;

    nearest_neighbor_scale_to_gray_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int unsigned clamp_size(int unsigned raw, int unsigned hi);
        if (raw == 0) return 1;
        if (raw > hi) return hi;
        return raw;
    endfunction

    // Mirror a register write, with the same masking and clamping as the block
    function automatic void apply_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            REG_SRC_WIDTH:  src_w = clamp_size(32'(value[SRC_DIM_W-1:0]), 32'(SRC_DIM_MAX));
            REG_SRC_HEIGHT: src_h = clamp_size(32'(value[SRC_DIM_W-1:0]), 32'(SRC_DIM_MAX));
            REG_TGT_WIDTH:  tgt_w = clamp_size(32'(value[TGT_DIM_W-1:0]), 32'(TGT_DIM_MAX));
            REG_TGT_HEIGHT: tgt_h = clamp_size(32'(value[TGT_DIM_W-1:0]), 32'(TGT_DIM_MAX));
            REG_CHANNELS:   chan_code = (value[2:0] == CH_RGBA) ? CH_RGBA : CH_RGB;
            default: ;
        endcase
    endfunction

    // Store index that the next emit will read
    function automatic int unsigned next_source_index();
        int unsigned x;
        int unsigned y;
        x = (out_col >= tgt_w) ? 0 : out_col;
        y = (out_row >= tgt_h) ? 0 : out_row;
        return (((y * src_h) / tgt_h) * src_w + (x * src_w) / tgt_w) % MIRROR_DEPTH;
    endfunction

    // Advance the scaler model by one accepted transfer
    function automatic void predict_transfer(in_item_t it);
        int unsigned nxt;
        int unsigned x;
        int unsigned y;
        int unsigned lum;
        logic [31:0] pix;
        out_item_t   px;
        if (it.op == OP_LOAD) begin
            pixel_mirror[load_addr % MIRROR_DEPTH] =
                {it.in_alpha, it.in_blue, it.in_green, it.in_red};
            pixel_loaded[load_addr % MIRROR_DEPTH] = 1'b1;
            nxt = load_addr + 1;
            if (nxt >= src_w * src_h || nxt >= MIRROR_DEPTH) nxt = 0;
            load_addr = nxt;
            n_loads++;
        end else begin
            pix = pixel_mirror[next_source_index()];
            if (out_col >= tgt_w) out_col = 0;
            if (out_row >= tgt_h) out_row = 0;
            x = out_col;
            y = out_row;
            lum = 32'(GRAY_W_R) * 32'(pix[7:0]) + 32'(GRAY_W_G) * 32'(pix[15:8])
                + 32'(GRAY_W_B) * 32'(pix[23:16]);
            px.out_red    = pix[7:0];
            px.out_green  = pix[15:8];
            px.out_blue   = pix[23:16];
            px.out_alpha  = (chan_code == CH_RGBA) ? pix[31:24] : 8'd0;
            px.gray_level = 8'(lum >> 16);
            px.frame_end  = (x + 1 == tgt_w) && (y + 1 == tgt_h);
            pending_pixels.push_back(px);
            // Step the raster position, wrap after the last pixel
            if (x + 1 >= tgt_w) begin
                out_col = 0;
                out_row = (y + 1 >= tgt_h) ? 0 : y + 1;
            end else begin
                out_col = x + 1;
            end
            n_emits++;
        end
    endfunction

    function automatic in_item_t make_load(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic [7:0] a);
        in_item_t it;
        it.op       = OP_LOAD;
        it.in_red   = r;
        it.in_green = g;
        it.in_blue  = b;
        it.in_alpha = a;
        return it;
    endfunction

    // Offer one item after a random gap; hold it until transfer
    task automatic send_transfer(input in_item_t it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_transfer(it);
    endtask

    // Random item; an emit that would read an unloaded pixel becomes a load
    task automatic send_random(input bit want_emit);
        in_item_t it;
        it = make_load(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        if (want_emit && pixel_loaded[next_source_index()]) it.op = OP_EMIT;
        send_transfer(it);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, value);
    endtask

    // Drop valid, wait for every pending pixel, then let the pipeline drain
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_sizes(input logic [31:0] sw, input logic [31:0] sh,
                               input logic [31:0] tw, input logic [31:0] th,
                               input logic [31:0] ch);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_TGT_WIDTH, tw);
        write_reg(REG_TGT_HEIGHT, th);
        write_reg(REG_CHANNELS, ch);
    endtask

    // Reset sizes: 256x256 to 256x256 RGB, so the first pixels map one to one
    task automatic test_reset_defaults();
        send_transfer(make_load(8'hFF, 8'h00, 8'h80, 8'hAA));
        send_transfer(make_load(8'h00, 8'hFF, 8'h01, 8'h55));
        send_transfer(make_load(8'h7F, 8'h80, 8'hFF, 8'hFF));
        repeat (3) send_random(1'b1);
    endtask

    // 2x2 to 3x3 full frame with wrap, then channel count and a shrunken target
    task automatic test_small_frame();
        settle();
        // Position (3,0) now lies past the 3-wide target and restarts at 0
        write_sizes(2, 2, 3, 3, 32'(CH_RGBA));
        // Load pointer 3 is the last pixel; the next loads wrap to 0
        send_transfer(make_load(8'h00, 8'h00, 8'h00, 8'h00));
        send_transfer(make_load(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_transfer(make_load(8'hFF, 8'h00, 8'h00, 8'h80));
        send_transfer(make_load(8'h00, 8'h00, 8'hFF, 8'h01));
        repeat (10) send_random(1'b1);
        settle();
        write_reg(REG_CHANNELS, 32'(CH_RGB));
        send_random(1'b1);
        settle();
        write_reg(REG_TGT_WIDTH, 1);
        send_random(1'b1);
    endtask

    // Hold the receiver off while items keep coming, so input stalls
    task automatic test_output_backpressure();
        settle();
        write_sizes(4, 4, 4, 4, 32'(CH_RGBA));
        repeat (16) send_random(1'b0);
        steady_mode  = 1'b1;
        hold_request = 300;
        repeat (40) send_random($urandom_range(0, 3) != 0);
        steady_mode = 1'b0;
    endtask

    // Phases of random items, each under its own register setting
    task automatic test_random_phases();
        int unsigned sent;
        int unsigned phase_len;
        logic [31:0] sw, sh, tw, th, ch;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            sw = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 16);
            sh = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 16);
            tw = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 24);
            th = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(1, 24);
            ch = $urandom_range(0, 1) ? 32'(CH_RGBA) : 32'(CH_RGB);
            case (n_phases % 6)
                0: begin
                    sw = 256;
                    sh = $urandom_range(1, 2);
                end
                1: begin
                    sw = 1;
                    sh = 256;
                end
                2: begin
                    tw = 4096;
                    th = 4096;
                end
                3: begin
                    tw = 1;
                    th = 1;
                end
                4: begin
                    // Out-of-range writes: zero, all ones, junk above the field
                    sw = $urandom & ~32'h1FF;
                    sh = 32'h1FF;
                    tw = 0;
                    th = 32'h1FFF;
                    ch = $urandom_range(0, 7);
                end
                default: ;
            endcase
            write_sizes(sw, sh, tw, th, ch);
            steady_mode = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(60, 120) + ((src_w * src_h > 64) ? src_w * src_h : 0);
            repeat (phase_len) send_random($urandom_range(0, 9) < 7);
            sent += phase_len;
            n_phases++;
        end
        steady_mode = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: random stalls, a long hold on request, and result checking
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, m_data);
                mismatches++;
            end else begin
                expected_px = pending_pixels.pop_front();
                check_field("out_red", expected_px.out_red, m_data.out_red);
                check_field("out_green", expected_px.out_green, m_data.out_green);
                check_field("out_blue", expected_px.out_blue, m_data.out_blue);
                check_field("out_alpha", expected_px.out_alpha, m_data.out_alpha);
                check_field("gray_level", expected_px.gray_level, m_data.gray_level);
                check_field("frame_end", 8'(expected_px.frame_end), 8'(m_data.frame_end));
                if (m_data.frame_end === 1'b1) n_frames++;
            end
        end
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    initial begin
        load_addr = 0;
        out_col   = 0;
        out_row   = 0;
        src_w     = 256;
        src_h     = 256;
        tgt_w     = 256;
        tgt_h     = 256;
        chan_code = CH_RGB;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_small_frame();
        test_output_backpressure();
        test_random_phases();
        settle();
        $display("Run covered %0d pixel loads and %0d output pixels (%0d frame ends)",
                 n_loads, n_emits, n_frames);
        $display("over %0d random size settings plus directed frames and a long stall",
                 n_phases);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

endmodule
